/* rtl/core/apt_pkg.sv */
// Shared types and constants for the affine point transform core.
`timescale 1ns / 1ps
`default_nettype none

package apt_pkg;

  // Fixed field widths of the request and result items.
  localparam int unsigned COORD_W          = 32;
  localparam int unsigned COEFF_W          = 16;
  localparam int unsigned NUM_AXES         = 3;
  localparam int unsigned ROW_W            = NUM_AXES * COEFF_W;
  localparam int unsigned KIND_W           = 2;
  localparam int unsigned COEFF_FRAC_DEF   = 12;

  // Configuration port geometry: 64-bit registers at 8-byte spacing.
  localparam int unsigned APB_DATA_W       = 64;
  localparam int unsigned APB_ADDR_W       = 6;
  localparam int unsigned REG_IDX_W        = 3;
  localparam int unsigned REG_IDX_LSB      = 3;

  // Identity matrix after reset.
  localparam logic [ROW_W-1:0] ROW0_RST = ROW_W'(64'd4096);
  localparam logic [ROW_W-1:0] ROW1_RST = ROW_W'(64'd268435456);
  localparam logic [ROW_W-1:0] ROW2_RST = ROW_W'(64'd17592186044416);

  // Register map.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROW0    = 3'd0,
    REG_ROW1    = 3'd1,
    REG_ROW2    = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_SHIFT_Z = 3'd5
  } reg_idx_e;

  // Request kind codes; the unused code behaves as a direction vector.
  typedef enum logic [KIND_W-1:0] {
    KIND_POINT  = 2'd0,
    KIND_VECTOR = 2'd1,
    KIND_NORMAL = 2'd2
  } kind_e;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;
  } req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      saturated;
  } res_t;

  // Matrix and translation column as seen by the datapath.
  typedef struct packed {
    logic [NUM_AXES-1:0][ROW_W-1:0]   rows;
    logic [NUM_AXES-1:0][COORD_W-1:0] shifts;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/core/apt_pipe.sv */
// Five-stage transform datapath: select, multiply, partial sums, round, saturate.
`timescale 1ns / 1ps
`default_nettype none

module apt_pipe #(
  parameter int unsigned COEFF_FRAC_BITS = apt_pkg::COEFF_FRAC_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire apt_pkg::cfg_t cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire apt_pkg::req_t in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output apt_pkg::res_t      out_res_o
);

  localparam int unsigned CW     = apt_pkg::COORD_W;
  localparam int unsigned KW     = apt_pkg::COEFF_W;
  localparam int unsigned NA     = apt_pkg::NUM_AXES;
  localparam int unsigned PROD_W = KW + CW;
  localparam int unsigned TR_W   = CW + COEFF_FRAC_BITS;
  localparam int unsigned ACC_W  = ((PROD_W > TR_W) ? PROD_W : TR_W) + 2;
  localparam int unsigned SH_W   = ACC_W - COEFF_FRAC_BITS;
  localparam int unsigned NSTG   = 5;

  localparam logic signed [ACC_W-1:0] HALF =
    ACC_W'({{(ACC_W-1){1'b0}}, 1'b1} << (COEFF_FRAC_BITS - 1));
  localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  // Handshake: a stage moves when it is empty or its successor moves.
  logic [NSTG:1]   valid_q;
  logic [NSTG+1:1] ready;
  logic [NSTG-1:0] valid_in;

  always_comb begin
    ready[NSTG+1] = ~out_stall_i;
    for (int k = NSTG; k >= 1; k--) begin
      ready[k] = ~valid_q[k] | ready[k+1];
    end
    valid_in = {valid_q[NSTG-1:1], in_valid_i};
  end

  assign in_stall_o  = ~ready[1];
  assign out_valid_o = valid_q[NSTG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (ready[k]) begin
          valid_q[k] <= valid_in[k-1];
        end
      end
    end
  end

  // Stage 1: pick coefficients (transposed for normals) and the translation.
  logic signed [KW-1:0] coef_s1_q  [NA][NA];
  logic signed [CW-1:0] coord_s1_q [NA];
  logic signed [CW-1:0] trans_s1_q [NA];
  logic signed [KW-1:0] coef_d     [NA][NA];
  logic signed [CW-1:0] coord_d    [NA];
  logic signed [CW-1:0] trans_d    [NA];
  logic                 is_normal;
  logic                 is_point;

  always_comb begin
    is_normal = (in_req_i.kind == apt_pkg::KIND_NORMAL);
    is_point  = (in_req_i.kind == apt_pkg::KIND_POINT);
    coord_d[0] = in_req_i.in_x;
    coord_d[1] = in_req_i.in_y;
    coord_d[2] = in_req_i.in_z;
    for (int r = 0; r < NA; r++) begin
      trans_d[r] = is_point ? $signed(cfg_i.shifts[r]) : '0;
      for (int c = 0; c < NA; c++) begin
        coef_d[r][c] = is_normal ? $signed(cfg_i.rows[c][r*KW +: KW])
                                 : $signed(cfg_i.rows[r][c*KW +: KW]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[1] && in_valid_i) begin
      coef_s1_q  <= coef_d;
      coord_s1_q <= coord_d;
      trans_s1_q <= trans_d;
    end
  end

  // Stage 2: nine coefficient-by-coordinate products at full precision.
  logic signed [PROD_W-1:0] prod_s2_q  [NA][NA];
  logic signed [CW-1:0]     trans_s2_q [NA];

  always_ff @(posedge clk_i) begin
    if (ready[2] && valid_q[1]) begin
      for (int r = 0; r < NA; r++) begin
        trans_s2_q[r] <= trans_s1_q[r];
        for (int c = 0; c < NA; c++) begin
          prod_s2_q[r][c] <= PROD_W'(coef_s1_q[r][c]) * PROD_W'(coord_s1_q[c]);
        end
      end
    end
  end

  // Stage 3: two partial sums per row; the rounding half joins the translation.
  logic signed [ACC_W-1:0] suma_s3_q [NA];
  logic signed [ACC_W-1:0] sumb_s3_q [NA];

  always_ff @(posedge clk_i) begin
    if (ready[3] && valid_q[2]) begin
      for (int r = 0; r < NA; r++) begin
        suma_s3_q[r] <= ACC_W'(prod_s2_q[r][0]) + ACC_W'(prod_s2_q[r][1]);
        sumb_s3_q[r] <= ACC_W'(prod_s2_q[r][2])
                      + (ACC_W'(trans_s2_q[r]) <<< COEFF_FRAC_BITS) + HALF;
      end
    end
  end

  // Stage 4: final sum, then drop the coefficient fraction bits.
  logic signed [SH_W-1:0]  rnd_s4_q [NA];
  logic signed [ACC_W-1:0] acc_d    [NA];

  always_comb begin
    for (int r = 0; r < NA; r++) begin
      acc_d[r] = suma_s3_q[r] + sumb_s3_q[r];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[4] && valid_q[3]) begin
      for (int r = 0; r < NA; r++) begin
        rnd_s4_q[r] <= SH_W'(acc_d[r] >>> COEFF_FRAC_BITS);
      end
    end
  end

  // Stage 5: clip each component to the coordinate range into the output register.
  logic signed [CW-1:0] clip_d [NA];
  logic [NA-1:0]        over_d;
  apt_pkg::res_t        res_q;

  always_comb begin
    for (int r = 0; r < NA; r++) begin
      over_d[r] = ~((&rnd_s4_q[r][SH_W-1:CW-1]) | ~(|rnd_s4_q[r][SH_W-1:CW-1]));
      if (over_d[r]) begin
        clip_d[r] = rnd_s4_q[r][SH_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
        clip_d[r] = rnd_s4_q[r][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[5] && valid_q[4]) begin
      res_q.out_x     <= clip_d[0];
      res_q.out_y     <= clip_d[1];
      res_q.out_z     <= clip_d[2];
      res_q.saturated <= |over_d;
    end
  end

  assign out_res_o = res_q;

endmodule

`default_nettype wire

/* rtl/core/affine_point_transform_core.sv */
// Top level of the affine point transform: register file and datapath.
//
//  Channel  Direction  Handshake             Payload
//  request  in         in_valid_i/in_stall_o in_req_i  (apt_pkg::req_t)
//  result   out        out_valid_o/out_stall_i out_res_o (apt_pkg::res_t)
//  config   in         psel/penable/pwrite   paddr, pwdata, prdata (64-bit APB)
//
// One request is taken every cycle while in_stall_o is low; each result passes
// through the five register stages of the datapath before it shows on the
// output.
// Reset empties the pipeline and loads the identity matrix with no translation.
// A stalled result holds in the output register while earlier stages keep
// filling; the request side stalls only once every stage holds a request.
`timescale 1ns / 1ps
`default_nettype none

module affine_point_transform_core #(
  parameter int unsigned COEFF_FRAC_BITS = apt_pkg::COEFF_FRAC_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [apt_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [apt_pkg::APB_DATA_W-1:0] pwdata,
  output logic [apt_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire apt_pkg::req_t                  in_req_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output apt_pkg::res_t                       out_res_o
);

  localparam int unsigned RW = apt_pkg::ROW_W;
  localparam int unsigned CW = apt_pkg::COORD_W;
  localparam int unsigned DW = apt_pkg::APB_DATA_W;

  logic [apt_pkg::NUM_AXES-1:0][RW-1:0] row_q;
  logic [apt_pkg::NUM_AXES-1:0][CW-1:0] shift_q;
  logic                                 wr_en;
  logic [apt_pkg::REG_IDX_W-1:0]        reg_idx;
  apt_pkg::cfg_t                        cfg;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[apt_pkg::REG_IDX_LSB +: apt_pkg::REG_IDX_W];

  // Register writes; unknown addresses are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0]   <= apt_pkg::ROW0_RST;
      row_q[1]   <= apt_pkg::ROW1_RST;
      row_q[2]   <= apt_pkg::ROW2_RST;
      shift_q    <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        apt_pkg::REG_ROW0:    row_q[0]   <= pwdata[RW-1:0];
        apt_pkg::REG_ROW1:    row_q[1]   <= pwdata[RW-1:0];
        apt_pkg::REG_ROW2:    row_q[2]   <= pwdata[RW-1:0];
        apt_pkg::REG_SHIFT_X: shift_q[0] <= pwdata[CW-1:0];
        apt_pkg::REG_SHIFT_Y: shift_q[1] <= pwdata[CW-1:0];
        apt_pkg::REG_SHIFT_Z: shift_q[2] <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (reg_idx)
      apt_pkg::REG_ROW0:    prdata = DW'(row_q[0]);
      apt_pkg::REG_ROW1:    prdata = DW'(row_q[1]);
      apt_pkg::REG_ROW2:    prdata = DW'(row_q[2]);
      apt_pkg::REG_SHIFT_X: prdata = DW'(shift_q[0]);
      apt_pkg::REG_SHIFT_Y: prdata = DW'(shift_q[1]);
      apt_pkg::REG_SHIFT_Z: prdata = DW'(shift_q[2]);
      default:              prdata = '0;
    endcase
  end

  assign cfg.rows   = row_q;
  assign cfg.shifts = shift_q;

  apt_pipe #(
    .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
  ) u_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

endmodule

`default_nettype wire

/* rtl/core/apt_checker.sv */
// Port-level checks for the affine point transform core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module apt_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_i,
  input wire logic          out_valid_i,
  input wire logic          out_stall_i,
  input wire apt_pkg::res_t out_res_i
);

  localparam logic signed [apt_pkg::COORD_W-1:0] SAT_MAX =
    {1'b0, {(apt_pkg::COORD_W-1){1'b1}}};
  localparam logic signed [apt_pkg::COORD_W-1:0] SAT_MIN =
    {1'b1, {(apt_pkg::COORD_W-1){1'b0}}};

  logic idle_edge;
  assign idle_edge = ~(in_valid_i & ~in_stall_i) & ~out_stall_i;

  // A stalled result stays put.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_res_i))
    else $error("result changed while stalled");

  // Requests are only held off when a result is waiting downstream.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_i |-> out_valid_i && out_stall_i)
    else $error("request stalled with free output");

  // A clipped result carries at least one extreme component.
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_res_i.saturated |->
      out_res_i.out_x == SAT_MAX || out_res_i.out_x == SAT_MIN ||
      out_res_i.out_y == SAT_MAX || out_res_i.out_y == SAT_MIN ||
      out_res_i.out_z == SAT_MAX || out_res_i.out_z == SAT_MIN)
    else $error("saturation flag without clipped component");

  // A run of idle edges, with no new request and no result stall, drains the pipeline.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_edge && $past(idle_edge, 1) && $past(idle_edge, 2) &&
    $past(idle_edge, 3) && $past(idle_edge, 4) |=> !out_valid_i)
    else $error("result appeared without a request");

endmodule

bind affine_point_transform_core apt_checker u_apt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_i (in_stall_o),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_res_i  (out_res_o)
);

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the affine point transform core: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
  import apt_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned HOLD_CYCLES    = 120;
  localparam int unsigned PHASE_REQS     = 322;
  localparam int unsigned NUM_PHASES     = 6;
  localparam int unsigned PRESSURE_PHASE = 4;
  localparam int unsigned MAX_PRINTS     = 100;
  localparam int unsigned DIR_ROWS       = 22;

  // The spare kind code and the two unmapped register slots.
  localparam logic [KIND_W-1:0]    KIND_SPARE  = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] C_ONE = 32'sh0001_0000;
  localparam logic [COEFF_W-1:0]        K_MAX  = 16'h7FFF;
  localparam logic [COEFF_W-1:0]        K_MIN  = 16'h8000;
  localparam logic [COEFF_W-1:0]        K_HALF = 16'h0800;

  typedef enum int {
    MAT_RESET,
    MAT_NEG_FULL,
    MAT_POS_FULL,
    MAT_HALF,
    MAT_MODEST,
    MAT_RANDOM
  } matrix_style_e;

  typedef struct {
    matrix_style_e matrix;
    req_t          req;
    bit            typed;
    res_t          want;
  } dir_row_t;

  // Block inputs, all known from time zero.
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic                  in_valid_i  = 1'b0;
  req_t                  in_req_i    = '0;
  logic                  out_stall_i = 1'b0;

  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_stall_o;
  logic                  out_valid_o;
  res_t                  out_res_o;

  // Copy of the matrix and translation column as the block should hold them.
  logic [ROW_W-1:0]          row_m   [NUM_AXES] = '{ROW0_RST, ROW1_RST, ROW2_RST};
  logic signed [COORD_W-1:0] shift_m [NUM_AXES] = '{'0, '0, '0};

  res_t        transformed_q [$];
  int unsigned mismatch_cnt   = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;
  bit          hold_ask       = 1'b0;
  bit          hold_done      = 1'b0;

  dir_row_t      dir_tbl    [DIR_ROWS];
  matrix_style_e phase_mats [NUM_PHASES] =
    '{MAT_RANDOM, MAT_MODEST, MAT_NEG_FULL, MAT_MODEST, MAT_POS_FULL, MAT_RANDOM};

  affine_point_transform_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Apply the mirrored matrix to one request: exact sum, round half up, saturate.
  function automatic res_t transform_coords(req_t r);
    logic signed [COORD_W-1:0] p [NUM_AXES];
    logic signed [COORD_W-1:0] o [NUM_AXES];
    logic signed [COEFF_W-1:0] k;
    longint                    acc;
    logic                      clipped;
    res_t                      res;
    p[0] = r.in_x;
    p[1] = r.in_y;
    p[2] = r.in_z;
    clipped = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      acc = 0;
      for (int c = 0; c < NUM_AXES; c++) begin
        // Normals use the transpose of the 3x3 block.
        if (r.kind == KIND_NORMAL) k = row_m[c][a*COEFF_W +: COEFF_W];
        else k = row_m[a][c*COEFF_W +: COEFF_W];
        acc += longint'(k) * longint'(p[c]);
      end
      if (r.kind == KIND_POINT) acc += longint'(shift_m[a]) <<< COEFF_FRAC_DEF;
      acc = (acc + (longint'(1) <<< (COEFF_FRAC_DEF - 1))) >>> COEFF_FRAC_DEF;
      if (acc > longint'(C_MAX)) begin
        o[a] = C_MAX;
        clipped = 1'b1;
      end else if (acc < longint'(C_MIN)) begin
        o[a] = C_MIN;
        clipped = 1'b1;
      end else begin
        o[a] = COORD_W'(acc);
      end
    end
    res.out_x = o[0];
    res.out_y = o[1];
    res.out_z = o[2];
    res.saturated = clipped;
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    if (mismatch_cnt < MAX_PRINTS) $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    mismatch_cnt++;
  endtask

  // Coordinates: half full range, some small, the rest special values such as the extremes.
  function automatic logic signed [COORD_W-1:0] pick_coord();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return $urandom;
    if (roll < 85) return COORD_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
    case ($urandom_range(0, 4))
      0: return C_MAX;
      1: return C_MIN;
      2: return '0;
      3: return '1;
      default: return C_ONE;
    endcase
  endfunction

  function automatic req_t pick_request();
    req_t        r;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) r.kind = KIND_POINT;
    else if (roll < 65) r.kind = KIND_VECTOR;
    else if (roll < 95) r.kind = KIND_NORMAL;
    else r.kind = KIND_SPARE;
    r.in_x = pick_coord();
    r.in_y = pick_coord();
    r.in_z = pick_coord();
    return r;
  endfunction

  // One APB write; psel stays up so that writes can follow back to back.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx) << REG_IDX_LSB;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_ROW0, REG_ROW1, REG_ROW2: row_m[idx] = val[ROW_W-1:0];
      REG_SHIFT_X, REG_SHIFT_Y, REG_SHIFT_Z: shift_m[idx - REG_SHIFT_X] = val[COORD_W-1:0];
      default: ;
    endcase
  endtask

  // Write every register for the chosen matrix style, then the unmapped slots.
  task automatic load_matrix(input matrix_style_e style);
    logic [APB_DATA_W-1:0] row_val;
    logic [COORD_W-1:0]    shift_val;
    for (int a = 0; a < NUM_AXES; a++) begin
      row_val   = {$urandom, $urandom};
      shift_val = $urandom;
      case (style)
        MAT_NEG_FULL: begin
          row_val[ROW_W-1:0] = {NUM_AXES{K_MIN}};
          shift_val = C_MAX;
        end
        MAT_POS_FULL: begin
          row_val[ROW_W-1:0] = {NUM_AXES{K_MAX}};
          shift_val = C_MIN;
        end
        MAT_HALF: begin
          row_val[ROW_W-1:0] = {NUM_AXES{K_HALF}};
          shift_val = '1;
        end
        MAT_MODEST: begin
          for (int c = 0; c < NUM_AXES; c++)
            row_val[c*COEFF_W +: COEFF_W] = COEFF_W'(int'($urandom_range(0, 12288)) - 6144);
          shift_val = COORD_W'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
        end
        default: ;
      endcase
      write_reg(REG_IDX_W'(REG_ROW0 + a), row_val);
      write_reg(REG_IDX_W'(REG_SHIFT_X + a), {$urandom, shift_val});
    end
    write_reg(REG_SPARE_A, {$urandom, $urandom});
    write_reg(REG_SPARE_B, {$urandom, $urandom});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one request, with an optional gap first, and record what it should give.
  task automatic offer(input req_t r, input bit typed, input res_t want);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    transformed_q.push_back(typed ? want : transform_coords(r));
  endtask

  task automatic wait_idle();
    while (transformed_q.size() != 0) @(posedge clk_i);
  endtask

  // Result side back-pressure, including one long hold-off.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_ask && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (transformed_q.size() == 0) begin
        flag_mismatch("result with nothing expected", out_res_o.out_x, 0);
      end else begin
        want = transformed_q.pop_front();
        if (out_res_o.out_x !== want.out_x) flag_mismatch("out_x", out_res_o.out_x, want.out_x);
        if (out_res_o.out_y !== want.out_y) flag_mismatch("out_y", out_res_o.out_y, want.out_y);
        if (out_res_o.out_z !== want.out_z) flag_mismatch("out_z", out_res_o.out_z, want.out_z);
        if (out_res_o.saturated !== want.saturated)
          flag_mismatch("saturated", out_res_o.saturated, want.saturated);
      end
    end
  end

  // Guard against a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    matrix_style_e current;
    res_t          none;
    none = '0;

    // Identity after reset, then all coefficients at -8.0 with the largest shift,
    // then all coefficients at 0.5 with a shift of one step below zero.
    dir_tbl = '{
      '{MAT_RESET, '{KIND_POINT, C_ONE, 32'sh0002_0000, 32'sh0003_0000}, 1'b1,
        '{C_ONE, 32'sh0002_0000, 32'sh0003_0000, 1'b0}},
      '{MAT_RESET, '{KIND_VECTOR, C_MAX, C_MIN, '0}, 1'b1, '{C_MAX, C_MIN, '0, 1'b0}},
      '{MAT_RESET, '{KIND_NORMAL, C_MIN, C_MAX, '1}, 1'b1, '{C_MIN, C_MAX, '1, 1'b0}},
      '{MAT_RESET, '{KIND_SPARE, 32'shFFFE_8000, 32'sd1, C_MAX}, 1'b1,
        '{32'shFFFE_8000, 32'sd1, C_MAX, 1'b0}},
      '{MAT_RESET, '{KIND_POINT, '0, '0, '0}, 1'b1, '{'0, '0, '0, 1'b0}},
      '{MAT_RESET, '{KIND_NORMAL, 32'sh1234_5678, 32'shEDCB_A987, 32'sh0F0F_0F0F}, 1'b0, '0},
      '{MAT_NEG_FULL, '{KIND_POINT, C_MAX, C_MAX, C_MAX}, 1'b1, '{C_MIN, C_MIN, C_MIN, 1'b1}},
      '{MAT_NEG_FULL, '{KIND_VECTOR, C_MIN, C_MIN, C_MIN}, 1'b1, '{C_MAX, C_MAX, C_MAX, 1'b1}},
      '{MAT_NEG_FULL, '{KIND_NORMAL, C_MIN, C_MIN, C_MIN}, 1'b1, '{C_MAX, C_MAX, C_MAX, 1'b1}},
      '{MAT_NEG_FULL, '{KIND_SPARE, C_MAX, C_MAX, C_MAX}, 1'b1, '{C_MIN, C_MIN, C_MIN, 1'b1}},
      '{MAT_NEG_FULL, '{KIND_POINT, '0, '0, '0}, 1'b1, '{C_MAX, C_MAX, C_MAX, 1'b0}},
      '{MAT_NEG_FULL, '{KIND_VECTOR, '0, '0, '0}, 1'b1, '{'0, '0, '0, 1'b0}},
      '{MAT_NEG_FULL, '{KIND_POINT, C_ONE, -C_ONE, 32'sd1}, 1'b0, '0},
      '{MAT_HALF, '{KIND_VECTOR, 32'sd1, '0, '0}, 1'b1, '{32'sd1, 32'sd1, 32'sd1, 1'b0}},
      '{MAT_HALF, '{KIND_VECTOR, '1, '0, '0}, 1'b1, '{'0, '0, '0, 1'b0}},
      '{MAT_HALF, '{KIND_VECTOR, 32'sd3, '0, '0}, 1'b1, '{32'sd2, 32'sd2, 32'sd2, 1'b0}},
      '{MAT_HALF, '{KIND_VECTOR, -32'sd3, '0, '0}, 1'b1, '{'1, '1, '1, 1'b0}},
      '{MAT_HALF, '{KIND_POINT, 32'sd1, '0, '0}, 1'b1, '{'0, '0, '0, 1'b0}},
      '{MAT_HALF, '{KIND_NORMAL, 32'sd1, 32'sd2, '0}, 1'b1, '{32'sd2, 32'sd2, 32'sd2, 1'b0}},
      '{MAT_HALF, '{KIND_VECTOR, C_MAX, C_MAX, C_MAX}, 1'b1, '{C_MAX, C_MAX, C_MAX, 1'b1}},
      '{MAT_HALF, '{KIND_POINT, C_MIN, C_MIN, C_MIN}, 1'b1, '{C_MIN, C_MIN, C_MIN, 1'b1}},
      '{MAT_HALF, '{KIND_NORMAL, C_ONE, 32'sd5, -32'sd7}, 1'b0, '0}
    };

    current        = MAT_RESET;
    send_idle_pct  = 32;
    recv_stall_pct = 64;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests; the matrix is reloaded whenever the table moves on.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tbl[i].matrix != current) begin
        in_valid_i <= 1'b0;
        wait_idle();
        load_matrix(dir_tbl[i].matrix);
        current = dir_tbl[i].matrix;
      end
      offer(dir_tbl[i].req, dir_tbl[i].typed, dir_tbl[i].want);
    end

    // Random phases, each with a freshly loaded matrix; the idling pattern changes every two phases.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      in_valid_i <= 1'b0;
      wait_idle();
      load_matrix(phase_mats[ph]);
      if (ph < 2) begin
        send_idle_pct  = 32;
        recv_stall_pct = 64;
      end else if (ph < 4) begin
        send_idle_pct  = 64;
        recv_stall_pct = 32;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      if (ph == PRESSURE_PHASE) hold_ask <= 1'b1;
      for (int n = 0; n < PHASE_REQS; n++) offer(pick_request(), 1'b0, none);
    end

    in_valid_i <= 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && transformed_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/apt_pkg.sv
rtl/core/apt_pipe.sv
rtl/core/affine_point_transform_core.sv
rtl/core/apt_checker.sv
verif/tb_top.sv
